// ===== design/sscp_pkg.sv =====
// ----------------------------------------------------------------------------
// sscp_pkg
// Shared widths, types and codes for the segment/sphere closest point core.
// ----------------------------------------------------------------------------
package sscp_pkg;

	// Coordinate and intermediate widths.
	localparam int COORD_W = 32;
	localparam int DIFF_W = COORD_W + 1;
	localparam int RAD_W = 31;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int DEN_W = PROD_W;
	localparam int NUM_W = PROD_W + 2;
	localparam int T_BITS = 30;
	localparam int OFF_W = DIFF_W + T_BITS;
	localparam int RSQ_W = 2 * RAD_W;
	localparam int CFG_IDX_W = 3;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0] diff_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [NUM_W-1:0] num_t;
	typedef logic [DEN_W-1:0] den_t;
	typedef logic [RAD_W-1:0] rad_t;
	typedef logic [T_BITS-1:0] frac_t;
	typedef logic [1:0] region_t;

	// Three-component vectors, index 0 is x, 1 is y, 2 is z.
	typedef coord_t [2:0] vec_t;
	typedef diff_t [2:0] dvec_t;

	// Region codes of a result.
	localparam region_t REGION_INTERIOR = 2'd0;
	localparam region_t REGION_START = 2'd1;
	localparam region_t REGION_END = 2'd2;
	localparam region_t REGION_DEGEN = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_START_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_END_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_END_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_END_Z = 3'd5;

	// Reset values: the segment runs from the origin to 1.0 on x.
	localparam coord_t START_RESET = 32'sh0000_0000;
	localparam coord_t END_X_RESET = 32'sh0001_0000;
	localparam coord_t END_YZ_RESET = 32'sh0000_0000;
	localparam diff_t DIR_X_RESET = 33'sh0_0001_0000;
	localparam diff_t DIR_YZ_RESET = 33'sh0_0000_0000;

	// Per-item data that rides along with the arithmetic.
	typedef struct packed {
		vec_t center;
		rad_t radius;
		region_t region;
	} side_t;

	// One finished result.
	typedef struct packed {
		vec_t near;
		logic colliding;
		region_t region;
	} res_t;

endpackage

// ===== design/sscp_proj.sv =====
// ----------------------------------------------------------------------------
// sscp_proj
// Projection front end: forms c - s, the dot products dot(d, c - s) and
// dot(d, d), and classifies the item by where the projection falls.
// ----------------------------------------------------------------------------
module sscp_proj (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  sscp_pkg::vec_t      center,
	input  sscp_pkg::rad_t      radius,
	input  sscp_pkg::vec_t      seg_start,
	input  sscp_pkg::dvec_t     dir,
	output logic                out_valid,
	output sscp_pkg::den_t      rem,
	output sscp_pkg::den_t      den,
	output sscp_pkg::side_t     side
);

	logic v_s1, v_s2, v_s3, v_s4;

	sscp_pkg::dvec_t w_s1;
	sscp_pkg::vec_t c_s1, c_s2, c_s3;
	sscp_pkg::rad_t rad_s1, rad_s2, rad_s3;

	sscp_pkg::prod_t [2:0] pd_s2;
	sscp_pkg::prod_t [2:0] pn_s2;

	sscp_pkg::den_t den_s3;
	sscp_pkg::num_t num_s3;

	sscp_pkg::den_t rem_s4, den_s4;
	sscp_pkg::side_t side_s4;
	sscp_pkg::region_t region_c;

	// Valid bits move with the data whenever the pipeline advances.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Stage 1: offset of the centre from the segment start.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				w_s1[i] <= {center[i][sscp_pkg::COORD_W-1], center[i]}
					- {seg_start[i][sscp_pkg::COORD_W-1], seg_start[i]};
			end
			c_s1 <= center;
			rad_s1 <= radius;
		end
	end

	// Stage 2: exact signed products for both dot products.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pd_s2[i] <= $signed(dir[i]) * $signed(dir[i]);
				pn_s2[i] <= $signed(dir[i]) * $signed(w_s1[i]);
			end
			c_s2 <= c_s1;
			rad_s2 <= rad_s1;
		end
	end

	// Stage 3: sum the products. Squares are never negative.
	always_ff @(posedge clk) begin
		if (en) begin
			den_s3 <= sscp_pkg::den_t'(pd_s2[0]) + sscp_pkg::den_t'(pd_s2[1])
				+ sscp_pkg::den_t'(pd_s2[2]);
			num_s3 <= {{2{pn_s2[0][sscp_pkg::PROD_W-1]}}, pn_s2[0]}
				+ {{2{pn_s2[1][sscp_pkg::PROD_W-1]}}, pn_s2[1]}
				+ {{2{pn_s2[2][sscp_pkg::PROD_W-1]}}, pn_s2[2]};
			c_s3 <= c_s2;
			rad_s3 <= rad_s2;
		end
	end

	// Stage 4: classify the projection parameter.
	always_comb begin
		if (den_s3 == '0) begin
			region_c = sscp_pkg::REGION_DEGEN;
		end else if (num_s3[sscp_pkg::NUM_W-1] || num_s3 == '0) begin
			region_c = sscp_pkg::REGION_START;
		end else if ($unsigned(num_s3) >= {2'b00, den_s3}) begin
			region_c = sscp_pkg::REGION_END;
		end else begin
			region_c = sscp_pkg::REGION_INTERIOR;
		end
	end

	// For an interior item the numerator is below the denominator and fits.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s4 <= num_s3[sscp_pkg::DEN_W-1:0];
			den_s4 <= den_s3;
			side_s4.center <= c_s3;
			side_s4.radius <= rad_s3;
			side_s4.region <= region_c;
		end
	end

	assign out_valid = v_s4;
	assign rem = rem_s4;
	assign den = den_s4;
	assign side = side_s4;

endmodule

// ===== design/sscp_div.sv =====
// ----------------------------------------------------------------------------
// sscp_div
// Pipelined restoring divider: one quotient bit of t = num / den per stage,
// giving an unsigned fraction with T_BITS fraction bits, truncated.
// ----------------------------------------------------------------------------
module sscp_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  sscp_pkg::den_t      in_rem,
	input  sscp_pkg::den_t      in_den,
	input  sscp_pkg::side_t     in_side,
	output logic                out_valid,
	output sscp_pkg::frac_t     t,
	output sscp_pkg::side_t     side
);

	localparam int N = sscp_pkg::T_BITS;
	localparam int W = sscp_pkg::DEN_W;

	logic v_s [1:N];
	sscp_pkg::den_t rem_s [1:N];
	sscp_pkg::den_t den_s [1:N];
	sscp_pkg::frac_t t_s [1:N];
	sscp_pkg::side_t side_s [1:N];

	for (genvar k = 0; k < N; k++) begin : g_step
		logic v_in;
		sscp_pkg::den_t rem_in;
		sscp_pkg::den_t den_in;
		sscp_pkg::frac_t t_in;
		sscp_pkg::side_t side_in;
		logic [W:0] shl;
		logic [W+1:0] diff;
		logic fits;

		if (k == 0) begin : g_first
			assign v_in = in_valid;
			assign rem_in = in_rem;
			assign den_in = in_den;
			assign t_in = '0;
			assign side_in = in_side;
		end else begin : g_next
			assign v_in = v_s[k];
			assign rem_in = rem_s[k];
			assign den_in = den_s[k];
			assign t_in = t_s[k];
			assign side_in = side_s[k];
		end

		// Shift the partial remainder and try to subtract the divisor.
		assign shl = {rem_in, 1'b0};
		assign diff = {1'b0, shl} - {2'b00, den_in};
		assign fits = !diff[W+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= fits ? diff[W-1:0] : shl[W-1:0];
				den_s[k+1] <= den_in;
				t_s[k+1] <= {t_in[N-2:0], fits};
				side_s[k+1] <= side_in;
			end
		end
	end

	assign out_valid = v_s[N];
	assign t = t_s[N];
	assign side = side_s[N];

endmodule

// ===== design/sscp_near.sv =====
// ----------------------------------------------------------------------------
// sscp_near
// Back end: scales the direction by t, forms the closest point, and tests
// the squared distance from the centre against the squared radius.
// ----------------------------------------------------------------------------
module sscp_near (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  sscp_pkg::frac_t     t,
	input  sscp_pkg::side_t     in_side,
	input  sscp_pkg::vec_t      seg_start,
	input  sscp_pkg::vec_t      seg_end,
	input  sscp_pkg::dvec_t     dir,
	output logic                out_valid,
	output sscp_pkg::res_t      res
);

	localparam int OW = sscp_pkg::OFF_W;
	localparam int TB = sscp_pkg::T_BITS;
	localparam int CW = sscp_pkg::COORD_W;
	localparam int DW = sscp_pkg::DIFF_W;
	localparam logic [OW-1:0] ROUND_HALF = OW'(1) << (TB - 1);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic [OW-1:0] prod_s1 [3];
	logic [DW-1:0] q_s2 [3];
	sscp_pkg::side_t side_s1, side_s2, side_s3, side_s4, side_s5;
	sscp_pkg::vec_t near_s3, near_s4, near_s5;
	sscp_pkg::dvec_t g_s4;
	sscp_pkg::prod_t [2:0] sq_s5;
	logic [sscp_pkg::RSQ_W-1:0] rr_s5;
	sscp_pkg::res_t res_s6;

	logic [DW-1:0] mag [3];
	logic [OW-1:0] rounded [3];
	logic [DW:0] off [3];
	logic [DW:0] sum [3];
	sscp_pkg::vec_t near_c;
	sscp_pkg::den_t dist_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Stage 1: t times the magnitude of each direction component.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = dir[i][DW-1] ? (~dir[i] + 1'b1) : dir[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				prod_s1[i] <= OW'(mag[i]) * OW'(t);
			end
			side_s1 <= in_side;
		end
	end

	// Stage 2: round to the nearest coordinate unit, ties away from zero.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rounded[i] = prod_s1[i] + ROUND_HALF;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				q_s2[i] <= rounded[i][OW-1:TB];
			end
			side_s2 <= side_s1;
		end
	end

	// Stage 3: pick the closest point by region.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			off[i] = dir[i][DW-1] ? -{1'b0, q_s2[i]} : {1'b0, q_s2[i]};
			sum[i] = {{2{seg_start[i][CW-1]}}, seg_start[i]} + off[i];
		end
		case (side_s2.region)
			sscp_pkg::REGION_INTERIOR: begin
				for (int i = 0; i < 3; i++) begin
					near_c[i] = sum[i][CW-1:0];
				end
			end
			sscp_pkg::REGION_END: near_c = seg_end;
			default: near_c = seg_start;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			near_s3 <= near_c;
			side_s3 <= side_s2;
		end
	end

	// Stage 4: gap from the closest point to the centre.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				g_s4[i] <= {side_s3.center[i][CW-1], side_s3.center[i]}
					- {near_s3[i][CW-1], near_s3[i]};
			end
			near_s4 <= near_s3;
			side_s4 <= side_s3;
		end
	end

	// Stage 5: squared gaps and squared radius.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s5[i] <= $signed(g_s4[i]) * $signed(g_s4[i]);
			end
			rr_s5 <= sscp_pkg::RSQ_W'(side_s4.radius) * sscp_pkg::RSQ_W'(side_s4.radius);
			near_s5 <= near_s4;
			side_s5 <= side_s4;
		end
	end

	// Stage 6: squared distance and the collision compare.
	assign dist_sum = sscp_pkg::den_t'(sq_s5[0]) + sscp_pkg::den_t'(sq_s5[1])
		+ sscp_pkg::den_t'(sq_s5[2]);

	always_ff @(posedge clk) begin
		if (en) begin
			res_s6.near <= near_s5;
			res_s6.region <= side_s5.region;
			res_s6.colliding <= (side_s5.region != sscp_pkg::REGION_DEGEN)
				&& ({{(sscp_pkg::DEN_W - sscp_pkg::RSQ_W){1'b0}}, rr_s5} >= dist_sum);
		end
	end

	assign out_valid = v_s6;
	assign res = res_s6;

endmodule

// ===== design/sscp_obuf.sv =====
// ----------------------------------------------------------------------------
// sscp_obuf
// Two-entry output buffer. It decouples the pipeline from the output stall
// so that the pipeline enable depends on registered state only.
// ----------------------------------------------------------------------------
module sscp_obuf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	input  sscp_pkg::res_t      push_res,
	output logic                room,
	output logic                out_valid,
	output sscp_pkg::res_t      out_res,
	input  logic                out_stall
);

	sscp_pkg::res_t ent_q [2];
	logic rd_q;
	logic [1:0] cnt_q;
	logic push, pop, wr_ptr;

	assign room = (cnt_q != 2'd2);
	assign push = push_valid && room;
	assign out_valid = (cnt_q != 2'd0);
	assign pop = out_valid && !out_stall;
	assign wr_ptr = rd_q ^ cnt_q[0];
	assign out_res = ent_q[rd_q];

	// Occupancy and read pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			rd_q <= 1'b0;
		end else begin
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
			rd_q <= rd_q ^ pop;
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr] <= push_res;
		end
	end

endmodule

// ===== design/segment_sphere_closest_point_core.sv =====
// ----------------------------------------------------------------------------
// segment_sphere_closest_point_core
// Finds the point of a configured segment closest to a sphere centre and
// tests whether the sphere touches it. Coordinates are signed Q16.16. The
// core takes one item per clock while the output buffer has room. Each item
// passes through a four-stage dot-product front end, the 30-stage divider that
// forms the projection parameter, one quotient bit per stage, a six-stage
// interpolation and distance back end, and then the output buffer.
// The input is stalled only while the two-entry output buffer holds two
// results that have not been taken. Write the segment end points only while
// no item is in flight.
// ----------------------------------------------------------------------------
module segment_sphere_closest_point_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [sscp_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [sscp_pkg::COORD_W-1:0]           cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [sscp_pkg::COORD_W-1:0]    center_x,
	input  logic signed [sscp_pkg::COORD_W-1:0]    center_y,
	input  logic signed [sscp_pkg::COORD_W-1:0]    center_z,
	input  logic [sscp_pkg::RAD_W-1:0]             radius,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [sscp_pkg::COORD_W-1:0]    near_x,
	output logic signed [sscp_pkg::COORD_W-1:0]    near_y,
	output logic signed [sscp_pkg::COORD_W-1:0]    near_z,
	output logic                                   colliding,
	output logic [1:0]                             region
);

	localparam int CW = sscp_pkg::COORD_W;

	sscp_pkg::vec_t seg_start_q, seg_end_q;
	sscp_pkg::dvec_t dir_q;
	sscp_pkg::vec_t center;

	logic en;
	logic proj_valid, div_valid, near_valid;
	sscp_pkg::den_t proj_rem, proj_den;
	sscp_pkg::side_t proj_side, div_side;
	sscp_pkg::frac_t div_t;
	sscp_pkg::res_t near_res, out_res;

	// Segment end point registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_start_q[0] <= sscp_pkg::START_RESET;
			seg_start_q[1] <= sscp_pkg::START_RESET;
			seg_start_q[2] <= sscp_pkg::START_RESET;
			seg_end_q[0] <= sscp_pkg::END_X_RESET;
			seg_end_q[1] <= sscp_pkg::END_YZ_RESET;
			seg_end_q[2] <= sscp_pkg::END_YZ_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sscp_pkg::REG_START_X: seg_start_q[0] <= cfg_data;
				sscp_pkg::REG_START_Y: seg_start_q[1] <= cfg_data;
				sscp_pkg::REG_START_Z: seg_start_q[2] <= cfg_data;
				sscp_pkg::REG_END_X: seg_end_q[0] <= cfg_data;
				sscp_pkg::REG_END_Y: seg_end_q[1] <= cfg_data;
				sscp_pkg::REG_END_Z: seg_end_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Segment direction, registered from the end point registers, so it follows them in the next cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q[0] <= sscp_pkg::DIR_X_RESET;
			dir_q[1] <= sscp_pkg::DIR_YZ_RESET;
			dir_q[2] <= sscp_pkg::DIR_YZ_RESET;
		end else begin
			for (int i = 0; i < 3; i++) begin
				dir_q[i] <= {seg_end_q[i][CW-1], seg_end_q[i]}
					- {seg_start_q[i][CW-1], seg_start_q[i]};
			end
		end
	end

	assign center[0] = center_x;
	assign center[1] = center_y;
	assign center[2] = center_z;

	// The whole pipeline advances together while the output buffer has room.
	assign in_stall = !en;

	sscp_proj u_proj (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.center    (center),
		.radius    (radius),
		.seg_start (seg_start_q),
		.dir       (dir_q),
		.out_valid (proj_valid),
		.rem       (proj_rem),
		.den       (proj_den),
		.side      (proj_side)
	);

	sscp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (proj_valid),
		.in_rem    (proj_rem),
		.in_den    (proj_den),
		.in_side   (proj_side),
		.out_valid (div_valid),
		.t         (div_t),
		.side      (div_side)
	);

	sscp_near u_near (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (div_valid),
		.t         (div_t),
		.in_side   (div_side),
		.seg_start (seg_start_q),
		.seg_end   (seg_end_q),
		.dir       (dir_q),
		.out_valid (near_valid),
		.res       (near_res)
	);

	sscp_obuf u_obuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (near_valid),
		.push_res   (near_res),
		.room       (en),
		.out_valid  (out_valid),
		.out_res    (out_res),
		.out_stall  (out_stall)
	);

	assign near_x = out_res.near[0];
	assign near_y = out_res.near[1];
	assign near_z = out_res.near[2];
	assign colliding = out_res.colliding;
	assign region = out_res.region;

	// The input is held off only while finished results are waiting.
	a_stall_means_pending: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result pending");

	// A degenerate segment never reports a collision.
	a_degen_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && region == sscp_pkg::REGION_DEGEN |-> !colliding)
		else $error("collision reported for a degenerate segment");

	// A result clamped to the start gives the start point.
	a_start_point: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && region == sscp_pkg::REGION_START
		|-> near_x == seg_start_q[0] && near_y == seg_start_q[1]
			&& near_z == seg_start_q[2])
		else $error("start-clamped result is not the start point");

	// A result clamped to the end gives the end point.
	a_end_point: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && region == sscp_pkg::REGION_END
		|-> near_x == seg_end_q[0] && near_y == seg_end_q[1]
			&& near_z == seg_end_q[2])
		else $error("end-clamped result is not the end point");

	// An interior point lies between the end points on x.
	a_interior_x: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && region == sscp_pkg::REGION_INTERIOR
		|-> ($signed(near_x) >= $signed(seg_start_q[0])
				&& $signed(near_x) <= $signed(seg_end_q[0]))
			|| ($signed(near_x) <= $signed(seg_start_q[0])
				&& $signed(near_x) >= $signed(seg_end_q[0])))
		else $error("interior point lies outside the segment on x");

endmodule

// ===== sim/segment_sphere_closest_point_checker.sv =====
// ----------------------------------------------------------------------------
// segment_sphere_closest_point_checker
// Watches the configuration port and both item channels of the closest point
// core. It keeps its own copy of the segment end points and computes the
// expected closest point, collision flag and region for each accepted sphere.
// It then compares every accepted result, field by field, with the oldest
// outstanding prediction.
// ----------------------------------------------------------------------------
module segment_sphere_closest_point_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [sscp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [sscp_pkg::COORD_W-1:0]         cfg_data,
	input  logic                                 in_valid,
	input  logic                                 in_stall,
	input  logic signed [sscp_pkg::COORD_W-1:0]  center_x,
	input  logic signed [sscp_pkg::COORD_W-1:0]  center_y,
	input  logic signed [sscp_pkg::COORD_W-1:0]  center_z,
	input  logic [sscp_pkg::RAD_W-1:0]           radius,
	input  logic                                 out_valid,
	input  logic                                 out_stall,
	input  logic signed [sscp_pkg::COORD_W-1:0]  near_x,
	input  logic signed [sscp_pkg::COORD_W-1:0]  near_y,
	input  logic signed [sscp_pkg::COORD_W-1:0]  near_z,
	input  logic                                 colliding,
	input  logic [1:0]                           region,
	output int                                   mismatch_count,
	output int                                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// Segment end points as the core should currently hold them.
	sscp_pkg::coord_t seg_start [3];
	sscp_pkg::coord_t seg_end [3];

	// Predicted results, oldest first.
	sscp_pkg::res_t expected_points [$];

	// Project the centre onto the segment, clamp, and test the squared distance.
	// All sums are exact at 80 bits, which is wider than any product here.
	function automatic sscp_pkg::res_t closest_point_on_segment(
			input sscp_pkg::coord_t cx, input sscp_pkg::coord_t cy,
			input sscp_pkg::coord_t cz, input sscp_pkg::rad_t rad);
		logic signed [79:0] dir_v [3];
		logic signed [79:0] cen_v [3];
		logic signed [79:0] near_v [3];
		logic signed [79:0] dot_dc, dot_dd, gap, dist_sq, rsq, off;
		logic [127:0] numer, denom;
		sscp_pkg::frac_t t_frac;
		logic [63:0] mag, scaled;
		sscp_pkg::res_t res;

		cen_v[0] = 80'(cx);
		cen_v[1] = 80'(cy);
		cen_v[2] = 80'(cz);
		dot_dc = 0;
		dot_dd = 0;
		for (int i = 0; i < 3; i++) begin
			dir_v[i] = 80'(seg_end[i]) - 80'(seg_start[i]);
			dot_dd += dir_v[i] * dir_v[i];
			dot_dc += dir_v[i] * (cen_v[i] - 80'(seg_start[i]));
		end

		res.colliding = 1'b0;
		if (dot_dd == 0) begin
			res.region = sscp_pkg::REGION_DEGEN;
			for (int i = 0; i < 3; i++)
				near_v[i] = 80'(seg_start[i]);
		end else if (dot_dc <= 0) begin
			res.region = sscp_pkg::REGION_START;
			for (int i = 0; i < 3; i++)
				near_v[i] = 80'(seg_start[i]);
		end else if (dot_dc >= dot_dd) begin
			res.region = sscp_pkg::REGION_END;
			for (int i = 0; i < 3; i++)
				near_v[i] = 80'(seg_end[i]);
		end else begin
			// Truncated fraction t, then each offset rounded half away from zero.
			res.region = sscp_pkg::REGION_INTERIOR;
			numer = 128'(dot_dc);
			denom = 128'(dot_dd);
			numer = numer << sscp_pkg::T_BITS;
			t_frac = sscp_pkg::frac_t'(numer / denom);
			for (int i = 0; i < 3; i++) begin
				mag = 64'((dir_v[i] < 0) ? -dir_v[i] : dir_v[i]);
				scaled = (64'(t_frac) * mag + (64'd1 << (sscp_pkg::T_BITS - 1)))
					>> sscp_pkg::T_BITS;
				off = {16'd0, scaled};
				near_v[i] = 80'(seg_start[i]) + ((dir_v[i] < 0) ? -off : off);
			end
		end

		// A degenerate segment never reports a collision.
		if (res.region != sscp_pkg::REGION_DEGEN) begin
			dist_sq = 0;
			for (int i = 0; i < 3; i++) begin
				gap = cen_v[i] - near_v[i];
				dist_sq += gap * gap;
			end
			rsq = {49'd0, rad};
			rsq = rsq * rsq;
			res.colliding = (rsq >= dist_sq);
		end

		for (int i = 0; i < 3; i++)
			res.near[i] = near_v[i][sscp_pkg::COORD_W-1:0];
		return res;
	endfunction

	task automatic check_field(input string field, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want_v, got_v);
			mismatch_count++;
		end
	endtask

	// Compare outputs, predict inputs, then apply any register write.
	always @(posedge clk or negedge arst_n) begin
		sscp_pkg::res_t want;
		if (!arst_n) begin
			for (int i = 0; i < 3; i++)
				seg_start[i] = sscp_pkg::START_RESET;
			seg_end[0] = sscp_pkg::END_X_RESET;
			seg_end[1] = sscp_pkg::END_YZ_RESET;
			seg_end[2] = sscp_pkg::END_YZ_RESET;
			expected_points.delete();
			mismatch_count = 0;
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_points.size() == 0) begin
					$display("%0t: unexpected item, expected none, actual %h %h %h %b %h",
						$time, near_x, near_y, near_z, colliding, region);
					mismatch_count++;
				end else begin
					want = expected_points.pop_front();
					check_field("near_x", want.near[0], near_x);
					check_field("near_y", want.near[1], near_y);
					check_field("near_z", want.near[2], near_z);
					check_field("colliding", 32'(want.colliding), 32'(colliding));
					check_field("region", 32'(want.region), 32'(region));
				end
			end

			if (in_valid && !in_stall)
				expected_points.push_back(
					closest_point_on_segment(center_x, center_y, center_z, radius));

			// Indexes past the end point registers are ignored.
			if (cfg_we) begin
				case (cfg_index)
					sscp_pkg::REG_START_X: seg_start[0] = cfg_data;
					sscp_pkg::REG_START_Y: seg_start[1] = cfg_data;
					sscp_pkg::REG_START_Z: seg_start[2] = cfg_data;
					sscp_pkg::REG_END_X:   seg_end[0] = cfg_data;
					sscp_pkg::REG_END_Y:   seg_end[1] = cfg_data;
					sscp_pkg::REG_END_Z:   seg_end[2] = cfg_data;
					default: ;
				endcase
			end

			pending = expected_points.size();
		end
	end

endmodule

// ===== sim/tb_segment_sphere_closest_point_core.sv =====
// ----------------------------------------------------------------------------
// tb_segment_sphere_closest_point_core
// Drives the closest point core with a directed set of spheres around the
// clamp boundaries, rounding ties, degenerate and full-range segments, then
// with random spheres aimed along a series of random segments. The receiver
// stalls at random. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_segment_sphere_closest_point_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PIPE_LATENCY = 40;
	localparam int CYCLE_LIMIT = 400000;
	localparam int ITEMS_PER_SEGMENT = 125;
	localparam int SEGMENT_COUNT = 14;

	// Indexes beyond the register list; writes there must have no effect.
	localparam logic [sscp_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [sscp_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	localparam sscp_pkg::coord_t Q_ONE = 32'sh0001_0000;
	localparam sscp_pkg::coord_t COORD_MAX = 32'sh7FFF_FFFF;
	localparam sscp_pkg::coord_t COORD_MIN = 32'sh8000_0000;
	localparam sscp_pkg::rad_t RAD_MAX = '1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [sscp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [sscp_pkg::COORD_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [sscp_pkg::COORD_W-1:0] center_x = '0;
	logic signed [sscp_pkg::COORD_W-1:0] center_y = '0;
	logic signed [sscp_pkg::COORD_W-1:0] center_z = '0;
	logic [sscp_pkg::RAD_W-1:0] radius = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [sscp_pkg::COORD_W-1:0] near_x;
	logic signed [sscp_pkg::COORD_W-1:0] near_y;
	logic signed [sscp_pkg::COORD_W-1:0] near_z;
	logic colliding;
	logic [1:0] region;
	int mismatch_count;
	int pending;

	// Segment currently loaded, used to aim random spheres.
	sscp_pkg::coord_t seg_s [3];
	sscp_pkg::coord_t seg_e [3];

	int send_idle_pct = 30;
	int recv_stall_pct = 71;
	int cycle_count;

	always #5 clk = ~clk;

	segment_sphere_closest_point_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.center_x  (center_x),
		.center_y  (center_y),
		.center_z  (center_z),
		.radius    (radius),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.near_x    (near_x),
		.near_y    (near_y),
		.near_z    (near_z),
		.colliding (colliding),
		.region    (region)
	);

	segment_sphere_closest_point_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.center_x       (center_x),
		.center_y       (center_y),
		.center_z       (center_z),
		.radius         (radius),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.near_x         (near_x),
		.near_y         (near_y),
		.near_z         (near_z),
		.colliding      (colliding),
		.region         (region),
		.mismatch_count (mismatch_count),
		.pending        (pending)
	);

	// Receiver back-pressure.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Run limit.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("simulation failed");
		$finish;
	end

	// Present one sphere, with optional idle cycles first, until it is accepted.
	task automatic send_point(input sscp_pkg::coord_t cx, input sscp_pkg::coord_t cy,
			input sscp_pkg::coord_t cz, input sscp_pkg::rad_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		center_x <= cx;
		center_y <= cy;
		center_z <= cz;
		radius <= r;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// Stop sending and wait until every result is back and the pipe is empty.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (PIPE_LATENCY + 8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [sscp_pkg::CFG_IDX_W-1:0] idx,
			input sscp_pkg::coord_t value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	// Load both end points; the spare indexes get junk that must be ignored.
	task automatic load_segment(input sscp_pkg::coord_t sx, input sscp_pkg::coord_t sy,
			input sscp_pkg::coord_t sz, input sscp_pkg::coord_t ex,
			input sscp_pkg::coord_t ey, input sscp_pkg::coord_t ez);
		seg_s[0] = sx;
		seg_s[1] = sy;
		seg_s[2] = sz;
		seg_e[0] = ex;
		seg_e[1] = ey;
		seg_e[2] = ez;
		write_reg(sscp_pkg::REG_START_X, sx);
		write_reg(sscp_pkg::REG_START_Y, sy);
		write_reg(sscp_pkg::REG_START_Z, sz);
		write_reg(sscp_pkg::REG_END_X, ex);
		write_reg(sscp_pkg::REG_END_Y, ey);
		write_reg(sscp_pkg::REG_END_Z, ez);
		write_reg(REG_SPARE_LO, $urandom);
		write_reg(REG_SPARE_HI, $urandom);
		cfg_we <= 1'b0;
	endtask

	// Random coordinate within roughly plus or minus 2^k raw units.
	function automatic sscp_pkg::coord_t rand_coord(input int k);
		sscp_pkg::coord_t v;
		v = $urandom;
		return v >>> (31 - k);
	endfunction

	function automatic sscp_pkg::coord_t saturate_coord(input longint v);
		if (v > COORD_MAX)
			return COORD_MAX;
		if (v < COORD_MIN)
			return COORD_MIN;
		return sscp_pkg::coord_t'(v);
	endfunction

	// Mostly spheres near the segment or its end points, with a radius of the
	// same scale as the offset, so hits and misses both occur; the rest are
	// fully random.
	task automatic random_point();
		longint dir_l, base, spread, noise, frac;
		int pick;
		bit to_end;
		sscp_pkg::coord_t c [3];
		sscp_pkg::rad_t r;

		pick = $urandom_range(99);
		to_end = $urandom_range(1);
		spread = longint'(1) << $urandom_range(24);
		frac = longint'($urandom_range(98304)) - 16384;
		for (int i = 0; i < 3; i++) begin
			dir_l = longint'(seg_e[i]) - longint'(seg_s[i]);
			if (pick < 70)
				base = longint'(seg_s[i]) + ((dir_l * frac) >>> 16);
			else
				base = to_end ? longint'(seg_e[i]) : longint'(seg_s[i]);
			noise = longint'($urandom_range(32'(2 * spread))) - spread;
			c[i] = saturate_coord(base + noise);
			if (pick >= 80)
				c[i] = $urandom;
		end
		if (pick < 80)
			r = sscp_pkg::rad_t'($urandom_range(32'(2 * spread)));
		else
			r = sscp_pkg::rad_t'($urandom);
		send_point(c[0], c[1], c[2], r);
	endtask

	// Main stimulus.
	initial begin
		int k;
		sscp_pkg::coord_t pts [6];

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset segment, origin to 1.0 on x: clamps, boundaries, extremes.
		send_point(Q_ONE / 2, 0, 0, 0);
		send_point(-Q_ONE, 0, 0, sscp_pkg::rad_t'(Q_ONE));
		send_point(-Q_ONE, 0, 0, sscp_pkg::rad_t'(Q_ONE - 1));
		send_point(2 * Q_ONE, 0, 0, 0);
		send_point(0, 5 * Q_ONE, 0, sscp_pkg::rad_t'(5 * Q_ONE));
		send_point(Q_ONE, -3 * Q_ONE, 0, 0);
		send_point(COORD_MAX, COORD_MAX, COORD_MAX, RAD_MAX);
		send_point(COORD_MIN, COORD_MIN, COORD_MIN, 0);
		send_point(Q_ONE / 3, COORD_MIN, COORD_MAX, RAD_MAX);

		// Half-unit offsets round away from zero in both directions.
		drain();
		load_segment(0, 0, 0, 1, 1, 0);
		send_point(1, 0, 0, 1);
		drain();
		load_segment(0, 0, 0, -1, -1, 0);
		send_point(-1, 0, 0, 0);

		// Zero-length segment: start point, never a collision.
		drain();
		load_segment(3 * Q_ONE, -2 * Q_ONE, 7 * Q_ONE, 3 * Q_ONE, -2 * Q_ONE, 7 * Q_ONE);
		send_point(3 * Q_ONE, -2 * Q_ONE, 7 * Q_ONE, RAD_MAX);
		send_point(COORD_MIN, COORD_MAX, 0, 0);

		// Full-range segments in both directions.
		drain();
		load_segment(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
		send_point(COORD_MAX, COORD_MAX, COORD_MAX, 0);
		send_point(COORD_MIN, COORD_MIN, COORD_MIN, RAD_MAX);
		send_point(0, 0, 0, RAD_MAX);
		send_point(Q_ONE, -Q_ONE, 12345, RAD_MAX);
		drain();
		load_segment(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN);
		send_point(0, 0, 0, 1);
		send_point(COORD_MAX, COORD_MIN, 0, RAD_MAX);
		send_point(-12345678, 98765432, 5, 1000);

		// Random spheres along a new random segment for each block.
		for (int blk = 0; blk < SEGMENT_COUNT; blk++) begin
			drain();
			if (blk == 5) begin
				send_idle_pct = 71;
				recv_stall_pct = 30;
			end else if (blk == 10) begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end

			k = (blk == 9 || blk == 12) ? 31 : $urandom_range(4, 30);
			for (int j = 0; j < 6; j++)
				pts[j] = rand_coord(k);
			if (blk == 6) begin
				// Degenerate segment.
				for (int j = 0; j < 3; j++)
					pts[j + 3] = pts[j];
			end else if (blk == 3) begin
				// Segment along x only.
				pts[4] = pts[1];
				pts[5] = pts[2];
			end
			load_segment(pts[0], pts[1], pts[2], pts[3], pts[4], pts[5]);

			for (int n = 0; n < ITEMS_PER_SEGMENT; n++) begin
				// Let the pipe run dry once in mid-stream.
				if (blk == 2 && n == ITEMS_PER_SEGMENT / 2)
					drain();
				random_point();
			end
		end

		drain();
		if (mismatch_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
